### rtl/lrfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfs_pkg
// Types and constants shared by the rectangle fill sequencer modules.
// ----------------------------------------------------------------------------
package lrfs_pkg;

    localparam int REG_W      = 13;   // size registers and coordinates
    localparam int CMD_W      = 2;
    localparam int XY_W       = 16;
    localparam int COLOUR_W   = 24;
    localparam int LINES_W    = 12;
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int VAL_W      = 15;   // signed operand of the row modulo
    localparam int MAG_W      = 14;   // magnitude of that operand
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = 2;

    // commands
    localparam logic [CMD_W-1:0] CMD_FILL   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PULL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SCROLL = 2'd2;

    // orientations
    localparam logic [1:0] ORIENT_LANDSCAPE     = 2'd0;
    localparam logic [1:0] ORIENT_PORTRAIT      = 2'd1;
    localparam logic [1:0] ORIENT_ROT_LANDSCAPE = 2'd2;
    localparam logic [1:0] ORIENT_ROT_PORTRAIT  = 2'd3;

    // register indexes
    localparam logic [1:0] REG_SCREEN_W = 2'd0;
    localparam logic [1:0] REG_SCREEN_H = 2'd1;
    localparam logic [1:0] REG_ORIENT   = 2'd2;
    localparam logic [1:0] REG_PANEL_H  = 2'd3;

    localparam logic [REG_W-1:0] RST_SCREEN_W = 13'd240;
    localparam logic [REG_W-1:0] RST_SCREEN_H = 13'd320;
    localparam logic [1:0]       RST_ORIENT   = ORIENT_PORTRAIT;
    localparam logic [REG_W-1:0] RST_PANEL_H  = 13'd320;

    // panel commands
    localparam logic [BYTE_W-1:0] BYTE_CASET = 8'h2A;
    localparam logic [BYTE_W-1:0] BYTE_RASET = 8'h2B;
    localparam logic [BYTE_W-1:0] BYTE_RAMWR = 8'h2C;

    typedef logic [REG_W-1:0] t_coord;

    typedef struct packed {
        logic                is_fill;   // 0: pull word
        t_coord              x_lo;
        t_coord              y_lo;      // rows already remapped
        t_coord              x_hi;
        t_coord              y_hi;
        t_coord              cols;      // columns minus one
        t_coord              rows;      // rows minus one
        logic [COLOUR_W-1:0] colour;
    } t_q_entry;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

endpackage

### rtl/lrfs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfs_in_if
// Command channel: fill, pull and scroll words.
// ----------------------------------------------------------------------------
interface lrfs_in_if;
    import lrfs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           command;
    logic signed [XY_W-1:0]     x_first;
    logic signed [XY_W-1:0]     y_first;
    logic signed [XY_W-1:0]     x_second;
    logic signed [XY_W-1:0]     y_second;
    logic [COLOUR_W-1:0]        fill_colour;
    logic [LINES_W-1:0]         scroll_lines;

    modport source (
        output valid, command, x_first, y_first, x_second, y_second,
               fill_colour, scroll_lines,
        input  ready
    );
    modport sink (
        input  valid, command, x_first, y_first, x_second, y_second,
               fill_colour, scroll_lines,
        output ready
    );
endinterface

### rtl/lrfs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfs_out_if
// Byte channel toward the serial shifter.
// ----------------------------------------------------------------------------
interface lrfs_out_if;
    import lrfs_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              is_command;
    logic              end_of_transfer;

    modport source (
        output valid, out_byte, is_command, end_of_transfer,
        input  ready
    );
    modport sink (
        input  valid, out_byte, is_command, end_of_transfer,
        output ready
    );
endinterface

### rtl/lrfs_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfs_mod
// Iterative non-negative modulo, one shift-subtract step per cycle.
// ----------------------------------------------------------------------------
module lrfs_mod (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [lrfs_pkg::VAL_W-1:0]   i_value,
    input  logic [lrfs_pkg::REG_W-1:0]          i_divisor,
    output logic                                o_done,
    output logic [lrfs_pkg::REG_W-1:0]          o_result
);
    import lrfs_pkg::*;

    localparam int SH_W = MAG_W + REG_W;
    localparam int K_W  = $clog2(MAG_W);

    logic               r_busy;
    logic               r_done;
    logic               r_neg;
    logic [MAG_W-1:0]   r_mag;
    logic [K_W-1:0]     r_k;

    logic signed [VAL_W-1:0] v_abs;
    logic [SH_W-1:0]         shifted;
    logic                    fits;

    always_comb begin
        v_abs   = i_value[VAL_W-1] ? -i_value : i_value;
        shifted = SH_W'(i_divisor) << r_k;
        fits    = SH_W'(r_mag) >= shifted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_k == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_value[VAL_W-1];
            r_mag <= v_abs[MAG_W-1:0];
            r_k   <= K_W'(MAG_W - 1);
        end else if (r_busy) begin
            if (fits) begin
                r_mag <= r_mag - shifted[MAG_W-1:0];
            end
            r_k <= r_k - 1'b1;
        end
    end

    // negative operand: fold the remainder back into [0, divisor)
    assign o_done   = r_done;
    assign o_result = (r_neg && r_mag != '0) ? i_divisor - REG_W'(r_mag)
                                             : REG_W'(r_mag);

endmodule

### rtl/lrfs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfs_queue
// Small FIFO of classified words between the front and back ends.
// ----------------------------------------------------------------------------
module lrfs_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  lrfs_pkg::t_q_entry    i_entry,
    input  logic                  i_pop,
    output lrfs_pkg::t_q_status   o_stat,
    output lrfs_pkg::t_q_entry    o_entry
);
    import lrfs_pkg::*;

    t_q_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_AW:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

    assign o_stat.valid = r_cnt != '0;
    assign o_stat.full  = r_cnt == (Q_AW+1)'(Q_DEPTH);
    assign o_entry      = r_mem[r_rp];

endmodule

### rtl/lrfs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfs_front
// Accepts command words: orders and clips fill corners, remaps rows by the
// scroll offset in the portrait modes, keeps the offset, and queues fills and pulls.
// ----------------------------------------------------------------------------
module lrfs_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    lrfs_in_if.sink                             i_in,
    input  logic [lrfs_pkg::REG_W-1:0]          i_dim_w,
    input  logic [lrfs_pkg::REG_W-1:0]          i_dim_h,
    input  logic [1:0]                          i_orient,
    input  logic [lrfs_pkg::REG_W-1:0]          i_panel_h,
    input  lrfs_pkg::t_q_status                 i_q_stat,
    output logic                                o_push,
    output lrfs_pkg::t_q_entry                  o_entry,
    output logic                                o_mod_start,
    output logic signed [lrfs_pkg::VAL_W-1:0]   o_mod_value,
    input  logic                                i_mod_done,
    input  logic [lrfs_pkg::REG_W-1:0]          i_mod_result
);
    import lrfs_pkg::*;

    localparam logic [2:0] F_IDLE     = 3'd0;
    localparam logic [2:0] F_LOAD     = 3'd1;
    localparam logic [2:0] F_FILL_MOD = 3'd2;
    localparam logic [2:0] F_PUSH     = 3'd3;
    localparam logic [2:0] F_SCROLL   = 3'd4;

    logic [2:0]          r_state;
    t_coord              r_off;
    t_coord              r_xa, r_xb, r_ya, r_yb, r_ya_m;
    logic [COLOUR_W-1:0] r_colour;

    logic                  in_ready, acc, portrait;
    logic signed [XY_W:0]  xa, xb, ya, yb, w_s, h_s;
    logic                  off_screen;
    t_coord                xa_c, xb_c, ya_c, yb_c;
    t_coord                cols, rows;
    logic [REG_W:0]        yb_sum;
    t_coord                yb_m;
    logic [VAL_W-1:0]      v_fill, v_scroll;

    assign in_ready   = (r_state == F_IDLE) && !i_q_stat.full;
    assign i_in.ready = in_ready;
    assign acc        = i_in.valid && in_ready;
    assign portrait   = (i_orient == ORIENT_PORTRAIT) || (i_orient == ORIENT_ROT_PORTRAIT);

    // corner ordering and clipping
    always_comb begin
        xa  = (i_in.x_second < i_in.x_first) ? XY_W'(i_in.x_second) : XY_W'(i_in.x_first);
        xb  = (i_in.x_second < i_in.x_first) ? XY_W'(i_in.x_first)  : XY_W'(i_in.x_second);
        ya  = (i_in.y_second < i_in.y_first) ? XY_W'(i_in.y_second) : XY_W'(i_in.y_first);
        yb  = (i_in.y_second < i_in.y_first) ? XY_W'(i_in.y_first)  : XY_W'(i_in.y_second);
        xa  = (i_in.x_second < i_in.x_first) ? {i_in.x_second[XY_W-1], i_in.x_second}
                                             : {i_in.x_first[XY_W-1], i_in.x_first};
        xb  = (i_in.x_second < i_in.x_first) ? {i_in.x_first[XY_W-1], i_in.x_first}
                                             : {i_in.x_second[XY_W-1], i_in.x_second};
        ya  = (i_in.y_second < i_in.y_first) ? {i_in.y_second[XY_W-1], i_in.y_second}
                                             : {i_in.y_first[XY_W-1], i_in.y_first};
        yb  = (i_in.y_second < i_in.y_first) ? {i_in.y_first[XY_W-1], i_in.y_first}
                                             : {i_in.y_second[XY_W-1], i_in.y_second};
        w_s = $signed((XY_W+1)'(i_dim_w));
        h_s = $signed((XY_W+1)'(i_dim_h));
        off_screen = (xb < 0) || (xa >= w_s) || (yb < 0) || (ya >= h_s);
        xa_c = (xa < 0)     ? '0 : xa[REG_W-1:0];
        xb_c = (xb >= w_s)  ? i_dim_w - 1'b1 : xb[REG_W-1:0];
        ya_c = (ya < 0)     ? '0 : ya[REG_W-1:0];
        yb_c = (yb >= h_s)  ? i_dim_h - 1'b1 : yb[REG_W-1:0];
    end

    // row remap operands, both before the modulo
    always_comb begin
        case (i_orient)
            ORIENT_PORTRAIT:     v_fill = VAL_W'(r_ya) + VAL_W'(r_off);
            ORIENT_ROT_PORTRAIT: v_fill = VAL_W'(r_ya) + VAL_W'(i_panel_h) - VAL_W'(r_off);
            default:             v_fill = VAL_W'(r_ya);
        endcase
        if (i_orient == ORIENT_ROT_PORTRAIT) begin
            v_scroll = VAL_W'(r_off) + VAL_W'(i_panel_h) - VAL_W'(i_in.scroll_lines);
        end else begin
            v_scroll = VAL_W'(r_off) + VAL_W'(i_in.scroll_lines);
        end
    end

    assign o_mod_start = (r_state == F_LOAD) ||
                         (acc && i_in.command == CMD_SCROLL && portrait);
    assign o_mod_value = (r_state == F_LOAD) ? $signed(v_fill) : $signed(v_scroll);

    // last row follows the first by the row count, wrapping once at most
    always_comb begin
        cols   = r_xb - r_xa;
        rows   = r_yb - r_ya;
        yb_sum = {1'b0, r_ya_m} + {1'b0, rows};
        yb_m   = (yb_sum >= {1'b0, i_dim_h}) ? REG_W'(yb_sum - {1'b0, i_dim_h})
                                             : yb_sum[REG_W-1:0];
    end

    always_comb begin
        o_push  = 1'b0;
        o_entry = '0;
        if (r_state == F_PUSH) begin
            o_entry.is_fill = 1'b1;
            o_entry.x_lo    = r_xa;
            o_entry.y_lo    = r_ya_m;
            o_entry.x_hi    = r_xb;
            o_entry.y_hi    = yb_m;
            o_entry.cols    = cols;
            o_entry.rows    = rows;
            o_entry.colour  = r_colour;
            o_push          = !i_q_stat.full;
        end else if (acc && i_in.command == CMD_PULL) begin
            o_push = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_off   <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (acc && i_in.command == CMD_FILL && !off_screen) begin
                        r_state <= F_LOAD;
                    end else if (acc && i_in.command == CMD_SCROLL && portrait) begin
                        r_state <= F_SCROLL;
                    end
                end
                F_LOAD: r_state <= F_FILL_MOD;
                F_FILL_MOD: begin
                    if (i_mod_done) r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_q_stat.full) r_state <= F_IDLE;
                end
                F_SCROLL: begin
                    if (i_mod_done) begin
                        r_off   <= i_mod_result;
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && acc && i_in.command == CMD_FILL) begin
            r_xa     <= xa_c;
            r_xb     <= xb_c;
            r_ya     <= ya_c;
            r_yb     <= yb_c;
            r_colour <= i_in.fill_colour;
        end
        if (r_state == F_FILL_MOD && i_mod_done) begin
            r_ya_m <= i_mod_result;
        end
    end

endmodule

### rtl/lrfs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfs_back
// Byte sequencer: window commands, coordinates, then R, G, B per pixel.
// ----------------------------------------------------------------------------
module lrfs_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lrfs_pkg::t_q_status   i_q_stat,
    input  lrfs_pkg::t_q_entry    i_entry,
    output logic                  o_pop,
    lrfs_out_if.source            o_out
);
    import lrfs_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CASET  = 4'd1;
    localparam logic [3:0] S_XS_HI  = 4'd2;
    localparam logic [3:0] S_XS_LO  = 4'd3;
    localparam logic [3:0] S_XE_HI  = 4'd4;
    localparam logic [3:0] S_XE_LO  = 4'd5;
    localparam logic [3:0] S_RASET  = 4'd6;
    localparam logic [3:0] S_YS_HI  = 4'd7;
    localparam logic [3:0] S_YS_LO  = 4'd8;
    localparam logic [3:0] S_YE_HI  = 4'd9;
    localparam logic [3:0] S_YE_LO  = 4'd10;
    localparam logic [3:0] S_RAMWR  = 4'd11;
    localparam logic [3:0] S_PIXEL  = 4'd12;

    logic [3:0]          r_step;
    logic [1:0]          r_phase;
    logic                r_ov;
    t_coord              r_x_lo, r_y_lo, r_x_hi, r_y_hi;
    t_coord              r_cols, r_rows, r_reload;
    logic [COLOUR_W-1:0] r_colour;
    logic [BYTE_W-1:0]   r_byte;
    logic                r_cmd;
    logic                r_eot;

    logic                load_ok, fire, load_fill;
    logic [3:0]          n_step;
    logic [1:0]          n_phase;
    t_coord              n_cols, n_rows;
    logic [BYTE_W-1:0]   n_byte;
    logic                n_cmd, n_eot;
    logic [15:0]         coord;

    assign load_ok   = !r_ov || o_out.ready;
    assign o_pop     = i_q_stat.valid &&
                       (i_entry.is_fill || r_step == S_IDLE || load_ok);
    assign load_fill = o_pop && i_entry.is_fill;
    assign fire      = o_pop && !i_entry.is_fill && r_step != S_IDLE;

    always_comb begin
        case (r_step)
            S_XS_HI, S_XS_LO: coord = 16'(r_x_lo);
            S_XE_HI, S_XE_LO: coord = 16'(r_x_hi);
            S_YS_HI, S_YS_LO: coord = 16'(r_y_lo);
            default:          coord = 16'(r_y_hi);
        endcase
    end

    always_comb begin
        n_step  = r_step + 1'b1;
        n_phase = r_phase;
        n_cols  = r_cols;
        n_rows  = r_rows;
        n_cmd   = 1'b0;
        n_eot   = 1'b0;
        n_byte  = '0;
        case (r_step)
            S_CASET: begin
                n_byte = BYTE_CASET;
                n_cmd  = 1'b1;
            end
            S_RASET: begin
                n_byte = BYTE_RASET;
                n_cmd  = 1'b1;
            end
            S_RAMWR: begin
                n_byte = BYTE_RAMWR;
                n_cmd  = 1'b1;
            end
            S_XS_HI, S_XE_HI, S_YS_HI, S_YE_HI: n_byte = coord[15:8];
            S_XS_LO, S_XE_LO, S_YS_LO, S_YE_LO: n_byte = coord[7:0];
            S_PIXEL: begin
                n_step = S_PIXEL;
                case (r_phase)
                    2'd0:    n_byte = r_colour[23:16];
                    2'd1:    n_byte = r_colour[15:8];
                    default: n_byte = r_colour[7:0];
                endcase
                if (r_phase < 2'd2) begin
                    n_phase = r_phase + 1'b1;
                end else begin
                    n_phase = '0;
                    if (r_cols != '0) begin
                        n_cols = r_cols - 1'b1;
                    end else if (r_rows != '0) begin
                        n_rows = r_rows - 1'b1;
                        n_cols = r_reload;
                    end else begin
                        n_eot  = 1'b1;
                        n_step = S_IDLE;
                    end
                end
            end
            default: n_step = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= S_IDLE;
            r_phase <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (o_out.ready) r_ov <= 1'b0;
            if (load_fill) begin
                r_step  <= S_CASET;
                r_phase <= '0;
            end else if (fire) begin
                r_step  <= n_step;
                r_phase <= n_phase;
                r_ov    <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_fill) begin
            r_x_lo   <= i_entry.x_lo;
            r_y_lo   <= i_entry.y_lo;
            r_x_hi   <= i_entry.x_hi;
            r_y_hi   <= i_entry.y_hi;
            r_cols   <= i_entry.cols;
            r_rows   <= i_entry.rows;
            r_reload <= i_entry.cols;
            r_colour <= i_entry.colour;
        end else if (fire) begin
            r_cols <= n_cols;
            r_rows <= n_rows;
        end
        if (fire) begin
            r_byte <= n_byte;
            r_cmd  <= n_cmd;
            r_eot  <= n_eot;
        end
    end

    assign o_out.valid           = r_ov;
    assign o_out.out_byte        = r_byte;
    assign o_out.is_command      = r_cmd;
    assign o_out.end_of_transfer = r_eot;

endmodule

### rtl/lcd_rect_fill_sequencer.sv
`timescale 1ns / 1ps
// Pull: one word per cycle while the front end is idle and the queue is not full.
// Fill: clip, then a 14-step modulo unit for the row remap in the front end;
//   input is not ready meanwhile, while queued bytes keep flowing out.
// Scroll in the portrait modes: runs on the same modulo unit; elsewhere it has no effect.
// Reset (synchronous, active low): registers to 240/320/portrait/320, scroll offset
//   zero, queue empty, no transfer pending.
// ----------------------------------------------------------------------------
// lcd_rect_fill_sequencer
// Rectangle fill byte sequencer for a serial TFT panel, with APB configuration.
// ----------------------------------------------------------------------------
module lcd_rect_fill_sequencer #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lrfs_in_if.sink                          i_in,
    lrfs_out_if.source                       o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lrfs_pkg::ADDR_W-1:0]      paddr,
    input  logic [lrfs_pkg::DATA_W-1:0]      pwdata,
    output logic [lrfs_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);
    import lrfs_pkg::*;

    localparam int unsigned REG_MAX = (1 << REG_W) - 1;
    localparam int unsigned DIM_CAP = (MAX_DIM < REG_MAX) ? MAX_DIM : REG_MAX;

    logic [REG_W-1:0] r_screen_w, r_screen_h, r_panel_h;
    logic [1:0]       r_orient;
    logic [REG_W-1:0] dim_w, dim_h;
    logic             cfg_wr;

    logic                    q_push, q_pop;
    t_q_entry                q_in, q_out;
    t_q_status               q_stat;
    logic                    mod_start, mod_done;
    logic signed [VAL_W-1:0] mod_value;
    logic [REG_W-1:0]        mod_result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= RST_SCREEN_W;
            r_screen_h <= RST_SCREEN_H;
            r_orient   <= RST_ORIENT;
            r_panel_h  <= RST_PANEL_H;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SCREEN_W: r_screen_w <= pwdata[REG_W-1:0];
                REG_SCREEN_H: r_screen_h <= pwdata[REG_W-1:0];
                REG_ORIENT:   r_orient   <= pwdata[1:0];
                REG_PANEL_H:  r_panel_h  <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SCREEN_W: prdata = DATA_W'(r_screen_w);
            REG_SCREEN_H: prdata = DATA_W'(r_screen_h);
            REG_ORIENT:   prdata = DATA_W'(r_orient);
            REG_PANEL_H:  prdata = DATA_W'(r_panel_h);
            default:      prdata = '0;
        endcase
    end

    // zero counts as one, oversize saturates
    always_comb begin
        dim_w = (r_screen_w == '0) ? REG_W'(1) :
                (r_screen_w > DIM_CAP) ? REG_W'(DIM_CAP) : r_screen_w;
        dim_h = (r_screen_h == '0) ? REG_W'(1) :
                (r_screen_h > DIM_CAP) ? REG_W'(DIM_CAP) : r_screen_h;
    end

    lrfs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_dim_w      (dim_w),
        .i_dim_h      (dim_h),
        .i_orient     (r_orient),
        .i_panel_h    (r_panel_h),
        .i_q_stat     (q_stat),
        .o_push       (q_push),
        .o_entry      (q_in),
        .o_mod_start  (mod_start),
        .o_mod_value  (mod_value),
        .i_mod_done   (mod_done),
        .i_mod_result (mod_result)
    );

    lrfs_mod u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mod_start),
        .i_value   (mod_value),
        .i_divisor (dim_h),
        .o_done    (mod_done),
        .o_result  (mod_result)
    );

    lrfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_stat  (q_stat),
        .o_entry (q_out)
    );

    lrfs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_entry  (q_out),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("word pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_stat.valid)
        else $error("word popped from empty queue");

    a_mod_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_start |=> !i_in.ready)
        else $error("input ready while modulo unit runs");

    a_eot_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_command) |-> !o_out.end_of_transfer)
        else $error("end of transfer flagged on a command byte");

endmodule
